### hdl/c24lf_pkg.sv
// c24lf_pkg: shared types and constants for the CRC-24 line framer.
// No dependencies; used by every module in hdl/.
package c24lf_pkg;

  localparam int unsigned QUEUE_BYTES = 6;
  localparam int unsigned QUEUE_W     = 8 * QUEUE_BYTES;

  localparam logic [23:0] CRC_START = 24'd11994318;
  localparam logic [23:0] CRC_POLY  = 24'h864CFB;

  // command codes
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_LEN  = 2'd1;
  localparam logic [1:0] CMD_HDR  = 2'd2;
  localparam logic [1:0] CMD_FIN  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_LSTART = 2'd1;
  localparam logic [1:0] KIND_LCRC   = 2'd2;
  localparam logic [1:0] KIND_BCRC   = 2'd3;

  // register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_BPL  = 1'b1;

  localparam logic [7:0]  BPL_RESET = 8'd22;

  // expanded byte queue for one command, head byte in the top bits
  typedef struct packed {
    logic [QUEUE_W-1:0] bytes;
    logic [2:0]         count;
  } byte_queue_t;

endpackage

### hdl/c24lf_crc_unit.sv
// c24lf_crc_unit: one CRC-24 byte update, MSB first.
// Depends on c24lf_pkg.
module c24lf_crc_unit
  import c24lf_pkg::*;
(
  input  logic [23:0] crc_in,
  input  logic [7:0]  data,
  output logic [23:0] crc_out
);

  always_comb begin
    logic [23:0] c;
    c = crc_in ^ {data, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      c = c[23] ? ({c[22:0], 1'b0} ^ CRC_POLY) : {c[22:0], 1'b0};
    end
    crc_out = c;
  end

endmodule

### hdl/c24lf_cmd_expand.sv
// c24lf_cmd_expand: turns a command into its byte queue (data byte, length or header; empty for finish).
// Depends on c24lf_pkg.
module c24lf_cmd_expand
  import c24lf_pkg::*;
(
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  tag,
  input  logic [31:0] length,
  output byte_queue_t queue
);

  logic [13:0] diff;
  logic [7:0]  first2;

  // two-byte new-style length: only used when 192 <= length <= 8383
  assign diff   = length[13:0] - 14'd192;
  assign first2 = 8'd192 + {2'b00, diff[13:8]};

  always_comb begin
    queue = '0;
    unique case (cmd)
      CMD_BYTE: begin
        queue.bytes = {data_byte, 40'h0};
        queue.count = 3'd1;
      end
      CMD_LEN: begin
        queue.bytes = {length[15:8], length[7:0], 32'h0};
        queue.count = 3'd2;
      end
      CMD_HDR: begin
        if (tag < 6'd16) begin
          if (length > 32'd65535) begin
            queue.bytes = {2'b10, tag[3:0], 2'd2, length, 8'h00};
            queue.count = 3'd5;
          end else if (length > 32'd255) begin
            queue.bytes = {2'b10, tag[3:0], 2'd1, length[15:0], 24'h0};
            queue.count = 3'd3;
          end else begin
            queue.bytes = {2'b10, tag[3:0], 2'd0, length[7:0], 32'h0};
            queue.count = 3'd2;
          end
        end else begin
          if (length > 32'd8383) begin
            queue.bytes = {2'b11, tag, 8'hFF, length};
            queue.count = 3'd6;
          end else if (length > 32'd191) begin
            queue.bytes = {2'b11, tag, first2, diff[7:0], 24'h0};
            queue.count = 3'd3;
          end else begin
            queue.bytes = {2'b11, tag, length[7:0], 32'h0};
            queue.count = 3'd2;
          end
        end
      end
      CMD_FIN: begin
        queue.count = 3'd0;
      end
      default: queue.count = 3'd0;
    endcase
  end

endmodule

### hdl/crc24_line_framer.sv
// crc24_line_framer: top level, sequencer around a shared CRC-24 unit.
// Depends on c24lf_pkg, c24lf_crc_unit and c24lf_cmd_expand.
//
// Usage
//  - Input channel (in_valid/in_stall): one command item per handshake. The
//    block stalls while it works through an item; one item at a time.
//  - Output channel (out_valid/out_stall): one result item per handshake,
//    last marks the final result of a command. A single output register
//    holds the result; out_stall freezes the sequencer only when it needs
//    to emit, so CRC work carries on underneath a waiting result.
//  - Config channel (cfg_valid/cfg_ready): index 0 mode, index 1 bytes per
//    line. Always ready; write only while the block is idle.
//  - Sequence: per expanded byte a pass through the shared CRC unit for the
//    block CRC, then an emit state per result (line CRC, line start, byte),
//    the byte state reusing the unit for the line CRC. Finish emits the three
//    block CRC bytes raw, or the line CRC then the block CRC in line mode.
//    The next item is accepted in idle. For a byte command, S_BLK runs after
//    accept, then the emit state loads the first result into the output register.
//  - Reset (rst, synchronous): mode 1, 22 bytes per line, CRCs at the start
//    value, column and line count cleared, no output pending.
module crc24_line_framer
  import c24lf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  tag,
  input  logic [31:0] length,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [23:0] value,
  output logic [15:0] line_number,
  output logic        last,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a command
    S_BLK,    // block CRC update for the head byte
    S_LCRC,   // close the open line
    S_LSTART, // open a new numbered line
    S_BYTE,   // emit head byte, line CRC update
    S_FRAW,   // raw finish: three CRC bytes
    S_FLCRC,  // line finish: line CRC
    S_FBCRC   // line finish: block CRC
  } state_t;

  state_t             state;
  logic               mode;
  logic [7:0]         bytes_per_line;
  logic [23:0]        block_crc;
  logic [23:0]        seg_crc;
  logic [7:0]         column;
  logic [15:0]        line_count;
  logic               line_open;
  logic [QUEUE_W-1:0] q_bytes;
  logic [2:0]         q_count;
  logic [1:0]         fin_idx;

  byte_queue_t        exp_queue;
  logic [7:0]         head;
  logic [23:0]        crc_in;
  logic [23:0]        crc_out;
  logic               out_free;
  logic               emit;
  logic [8:0]         col_p1;
  logic [8:0]         width;
  logic [15:0]        line_count_p1;

  c24lf_cmd_expand u_expand (
    .cmd       (cmd),
    .data_byte (data_byte),
    .tag       (tag),
    .length    (length),
    .queue     (exp_queue)
  );

  // one CRC unit, shared: block CRC in S_BLK, line CRC otherwise
  assign head   = q_bytes[QUEUE_W-1 -: 8];
  assign crc_in = (state == S_BLK) ? block_crc : seg_crc;

  c24lf_crc_unit u_crc (
    .crc_in  (crc_in),
    .data    (head),
    .crc_out (crc_out)
  );

  assign out_free      = !out_valid || !out_stall;
  // a result is loaded this cycle
  assign emit          = out_free && (state == S_LCRC || state == S_LSTART ||
                                      state == S_BYTE || state == S_FRAW ||
                                      state == S_FLCRC || state == S_FBCRC);
  assign in_stall      = (state != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign col_p1        = {1'b0, column} + 9'd1;
  assign width         = (bytes_per_line == 8'd0) ? 9'd256 : {1'b0, bytes_per_line};
  assign line_count_p1 = line_count + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      mode           <= 1'b1;
      bytes_per_line <= BPL_RESET;
      block_crc      <= CRC_START;
      seg_crc        <= CRC_START;
      column         <= 8'd0;
      line_count     <= 16'd0;
      line_open      <= 1'b0;
      q_count        <= 3'd0;
      fin_idx        <= 2'd0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MODE: mode <= cfg_data[0];
          CFG_BPL:  bytes_per_line <= cfg_data;
          default:  ;
        endcase
      end

      // new result loaded, or a stalled one held
      out_valid <= emit || (out_valid && out_stall);

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            q_bytes <= exp_queue.bytes;
            q_count <= exp_queue.count;
            fin_idx <= 2'd0;
            if (cmd == CMD_FIN) state <= mode ? S_FLCRC : S_FRAW;
            else                state <= S_BLK;
          end
        end
        S_BLK: begin
          block_crc <= crc_out;
          if (!mode)            state <= S_BYTE;
          else if (column != 8'd0) state <= S_BYTE;
          else if (line_open)   state <= S_LCRC;
          else                  state <= S_LSTART;
        end
        S_LCRC: begin
          if (out_free) begin
            kind        <= KIND_LCRC;
            value       <= seg_crc;
            line_number <= 16'd0;
            last        <= 1'b0;
            seg_crc     <= CRC_START;
            state       <= S_LSTART;
          end
        end
        S_LSTART: begin
          if (out_free) begin
            kind        <= KIND_LSTART;
            value       <= 24'd0;
            line_number <= line_count_p1;
            last        <= 1'b0;
            line_count  <= line_count_p1;
            line_open   <= 1'b1;
            state       <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (out_free) begin
            kind        <= KIND_BYTE;
            value       <= {16'd0, head};
            line_number <= 16'd0;
            last        <= (q_count == 3'd1);
            if (mode) begin
              seg_crc <= crc_out;
              column  <= (col_p1 >= width) ? 8'd0 : col_p1[7:0];
            end
            q_bytes <= {q_bytes[QUEUE_W-9:0], 8'h00};
            q_count <= q_count - 3'd1;
            state   <= (q_count == 3'd1) ? S_IDLE : S_BLK;
          end
        end
        S_FRAW: begin
          if (out_free) begin
            kind        <= KIND_BYTE;
            line_number <= 16'd0;
            last        <= (fin_idx == 2'd2);
            unique case (fin_idx)
              2'd0:    value <= {16'd0, block_crc[23:16]};
              2'd1:    value <= {16'd0, block_crc[15:8]};
              default: value <= {16'd0, block_crc[7:0]};
            endcase
            fin_idx <= fin_idx + 2'd1;
            if (fin_idx == 2'd2) begin
              block_crc  <= CRC_START;
              seg_crc    <= CRC_START;
              column     <= 8'd0;
              line_count <= 16'd0;
              line_open  <= 1'b0;
              state      <= S_IDLE;
            end
          end
        end
        S_FLCRC: begin
          if (out_free) begin
            kind        <= KIND_LCRC;
            value       <= seg_crc;
            line_number <= 16'd0;
            last        <= 1'b0;
            state       <= S_FBCRC;
          end
        end
        S_FBCRC: begin
          if (out_free) begin
            kind        <= KIND_BCRC;
            value       <= block_crc;
            line_number <= line_count_p1;
            last        <= 1'b1;
            block_crc   <= CRC_START;
            seg_crc     <= CRC_START;
            column      <= 8'd0;
            line_count  <= 16'd0;
            line_open   <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // byte states always have a byte queued
  a_queue_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_BLK || state == S_LCRC || state == S_LSTART || state == S_BYTE)
      |-> (q_count != 3'd0 && q_count <= 3'd6))
    else $error("byte state with empty or oversized queue");

  // a new result only appears while an item is being worked on
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state != S_IDLE && state != S_BLK))
    else $error("result raised outside an emit state");

  // a line start always brings the line-open flag with it
  a_line_open: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_LSTART) |-> line_open)
    else $error("line start without open line");

  // back in idle, the last item delivered or pending carries last
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && $past(state != S_IDLE) && !$past(rst)) |-> (out_valid && last))
    else $error("item ended without a last result");

endmodule
